FILE: sv/dstwr_pkg.sv
// Shared types and constants for the DS-TWR time-of-flight block.
// No dependencies; imported by dstwr_div and ds_twr_time_of_flight.
`timescale 1ns / 1ps
`default_nettype none
package dstwr_pkg;

  localparam int unsigned OUT_BITS = 41;

  // control bits that ride along with each beat in the pipeline
  typedef struct packed {
    logic valid;
    logic zero;
    logic neg;
  } dstwr_ctl_t;

endpackage
`default_nettype wire

FILE: sv/ds_twr_time_of_flight.sv
// Asymmetric double-sided two-way ranging time of flight, top level.
// Depends on dstwr_pkg and dstwr_div.
//
// Input channel (in_valid_i / in_ready_o) carries the six timestamps of one
// poll / response / final exchange; output channel (out_valid_o /
// out_ready_i) carries flight_time_q8 = (Ra*Rb - ra*rb)/(Ra+Rb+ra+rb) with
// FRACTION_BITS fraction bits, truncated toward zero, plus zero_divisor.
// One beat in and one beat out per exchange.
//
// Stages: one for intervals, one for the two products, one for the
// difference, one per quotient bit in the divider pipeline, and one
// output register. Throughput: one exchange per cycle while the
// receiver takes beats.
//
// Reset clears all valid bits; the pipeline is then empty and ready.
// When the receiver stalls with a result held, the whole pipeline freezes
// and in_ready_o drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module ds_twr_time_of_flight #(
  parameter int unsigned STAMP_BITS    = 32,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire  [STAMP_BITS-1:0]  poll_tx_time_i,
  input  wire  [STAMP_BITS-1:0]  poll_rx_time_i,
  input  wire  [STAMP_BITS-1:0]  resp_tx_time_i,
  input  wire  [STAMP_BITS-1:0]  resp_rx_time_i,
  input  wire  [STAMP_BITS-1:0]  final_tx_time_i,
  input  wire  [STAMP_BITS-1:0]  final_rx_time_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output logic signed [dstwr_pkg::OUT_BITS-1:0] flight_time_q8_o,
  output logic                   zero_divisor_o
);
  import dstwr_pkg::*;

  localparam int unsigned SB = STAMP_BITS;
  localparam int unsigned DB = SB + 2;
  localparam int unsigned PB = 2 * SB;
  localparam int unsigned NB = PB + FRACTION_BITS;
  localparam int unsigned QW = ((NB > OUT_BITS) ? NB : OUT_BITS) + 1;

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // stage 1: wrapping intervals and divisor
  logic          v1_q;
  logic [SB-1:0] ra_round_q, ra_reply_q, rb_round_q, rb_reply_q;
  logic [DB-1:0] den1_q;

  // intervals wrap at the stamp width before they are summed
  logic [SB-1:0] ra_round_d, ra_reply_d, rb_round_d, rb_reply_d;
  assign ra_round_d = resp_rx_time_i - poll_tx_time_i;
  assign ra_reply_d = final_tx_time_i - resp_rx_time_i;
  assign rb_round_d = final_rx_time_i - resp_tx_time_i;
  assign rb_reply_d = resp_tx_time_i - poll_rx_time_i;

  // stage 2: products
  logic          v2_q;
  logic [PB-1:0] prod_p_q, prod_q_q;
  logic [DB-1:0] den2_q;

  // stage 3: magnitude of the difference, scaled
  dstwr_ctl_t    ctl3_q;
  logic [NB-1:0] num3_q;
  logic [DB-1:0] den3_q;

  dstwr_ctl_t    ctl_div;
  logic [NB-1:0] quot_div;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      ctl3_q <= '0;
    end else if (en) begin
      v1_q          <= in_valid_i;
      v2_q          <= v1_q;
      ctl3_q.valid  <= v2_q;
      ctl3_q.zero   <= (den2_q == '0);
      ctl3_q.neg    <= (prod_q_q > prod_p_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ra_round_q <= ra_round_d;
      ra_reply_q <= ra_reply_d;
      rb_round_q <= rb_round_d;
      rb_reply_q <= rb_reply_d;
      den1_q     <= DB'(ra_round_d) + DB'(ra_reply_d) + DB'(rb_round_d) + DB'(rb_reply_d);
      prod_p_q   <= PB'(ra_round_q * rb_round_q);
      prod_q_q   <= PB'(ra_reply_q * rb_reply_q);
      den2_q     <= den1_q;
      num3_q     <= NB'((prod_q_q > prod_p_q) ? (prod_q_q - prod_p_q)
                                               : (prod_p_q - prod_q_q)) << FRACTION_BITS;
      den3_q     <= den2_q;
    end
  end

  dstwr_div #(
    .NUM_BITS(NB),
    .DEN_BITS(DB)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (ctl3_q),
    .num_i  (num3_q),
    .den_i  (den3_q),
    .ctl_o  (ctl_div),
    .quot_o (quot_div)
  );

  // saturate, apply sign, register
  logic [QW-1:0] quot_ext, limit, mag, res;
  always_comb begin
    quot_ext = QW'(quot_div);
    limit    = ctl_div.neg ? (QW'(1) << (OUT_BITS - 1))
                           : ((QW'(1) << (OUT_BITS - 1)) - QW'(1));
    mag      = (quot_ext > limit) ? limit : quot_ext;
    res      = ctl_div.neg ? (QW'(0) - mag) : mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= ctl_div.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      flight_time_q8_o <= ctl_div.zero ? '0 : res[OUT_BITS-1:0];
      zero_divisor_o   <= ctl_div.zero;
    end
  end

  a_zero_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_divisor_o |-> flight_time_q8_o == '0)
    else $error("zero divisor with nonzero result");

  a_stall_freezes_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(ctl_div) && $stable(quot_div))
    else $error("divider pipeline moved during stall");

  a_sign_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_div.valid && en && !ctl_div.zero && quot_div != '0
    |=> flight_time_q8_o[OUT_BITS-1] == $past(ctl_div.neg))
    else $error("result sign does not follow numerator sign");

endmodule
`default_nettype wire

FILE: sv/dstwr_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on dstwr_pkg for the control struct carried with each beat.
`timescale 1ns / 1ps
`default_nettype none
module dstwr_div #(
  parameter int unsigned NUM_BITS = 72,
  parameter int unsigned DEN_BITS = 34
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   en_i,
  input  dstwr_pkg::dstwr_ctl_t ctl_i,
  input  wire  [NUM_BITS-1:0]   num_i,
  input  wire  [DEN_BITS-1:0]   den_i,
  output dstwr_pkg::dstwr_ctl_t ctl_o,
  output logic [NUM_BITS-1:0]   quot_o
);
  import dstwr_pkg::*;

  // numerator shifts out of the top while quotient bits shift in below
  dstwr_ctl_t          ctl_q [NUM_BITS];
  logic [NUM_BITS-1:0] nq_q  [NUM_BITS];
  logic [DEN_BITS-1:0] rem_q [NUM_BITS];
  logic [DEN_BITS-1:0] den_q [NUM_BITS];

  for (genvar g = 0; g < NUM_BITS; g++) begin : g_stage
    dstwr_ctl_t          ctl_s;
    logic [NUM_BITS-1:0] nq_s;
    logic [DEN_BITS-1:0] rem_s;
    logic [DEN_BITS-1:0] den_s;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;
    logic                ge;

    if (g == 0) begin : g_first
      assign ctl_s = ctl_i;
      assign nq_s  = num_i;
      assign rem_s = '0;
      assign den_s = den_i;
    end else begin : g_next
      assign ctl_s = ctl_q[g-1];
      assign nq_s  = nq_q[g-1];
      assign rem_s = rem_q[g-1];
      assign den_s = den_q[g-1];
    end

    assign trial = {rem_s, nq_s[NUM_BITS-1]};
    assign diff  = trial - {1'b0, den_s};
    assign ge    = trial >= {1'b0, den_s};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[g] <= '0;
      end else if (en_i) begin
        ctl_q[g] <= ctl_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[g]  <= {nq_s[NUM_BITS-2:0], ge};
        rem_q[g] <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        den_q[g] <= den_s;
      end
    end
  end

  assign ctl_o  = ctl_q[NUM_BITS-1];
  assign quot_o = nq_q[NUM_BITS-1];

endmodule
`default_nettype wire
